// ===== rtl/gvca_pkg.sv =====
// Shared types, constants and helpers for the grid vertex cluster assign block.
package gvca_pkg;

  localparam int MAX_RES     = 16;
  localparam int MAX_CELLS   = 4096;
  localparam int VERTEX_BITS = 20;
  localparam int COORD_BITS  = 24;
  localparam int CELL_BITS   = 12;
  localparam int RES_BITS    = 5;
  localparam int CRD_BITS    = 4;
  localparam int HALF_BITS   = 5;
  localparam int SCALE_BITS  = 24;
  localparam int SUM_BITS    = 44;
  localparam int CNT_BITS    = 21;
  localparam int CTR_BITS    = 13;
  localparam int PROD_BITS   = 48;
  localparam int DIST_BITS   = 50;

  localparam logic [CTR_BITS-1:0] CTR_MAX = 13'd8191;
  localparam logic [CNT_BITS-1:0] CNT_MAX = 21'h1FFFFF;
  localparam logic [SUM_BITS-1:0] SUM_MAX = 44'hFFFFFFFFFFF;

  localparam logic [2:0] CFG_RES_X   = 3'd0;
  localparam logic [2:0] CFG_RES_Y   = 3'd1;
  localparam logic [2:0] CFG_RES_Z   = 3'd2;
  localparam logic [2:0] CFG_SCALE_X = 3'd3;
  localparam logic [2:0] CFG_SCALE_Y = 3'd4;
  localparam logic [2:0] CFG_SCALE_Z = 3'd5;

  localparam logic OP_ASSOC = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic                   op;
    logic [VERTEX_BITS-1:0] vertex_id;
    logic [COORD_BITS-1:0]  pos_x;
    logic [COORD_BITS-1:0]  pos_y;
    logic [COORD_BITS-1:0]  pos_z;
    logic [CELL_BITS-1:0]   cell_addr;
  } in_t;

  typedef struct packed {
    logic [VERTEX_BITS-1:0] vertex_out;
    logic [CELL_BITS-1:0]   cell_index;
    logic [CELL_BITS-1:0]   cluster_id;
    logic                   created;
    logic                   cell_has_cluster;
    logic [SUM_BITS-1:0]    sum_x;
    logic [SUM_BITS-1:0]    sum_y;
    logic [SUM_BITS-1:0]    sum_z;
    logic [CNT_BITS-1:0]    member_count;
    logic [CTR_BITS-1:0]    clusters_made;
  } out_t;

  typedef struct packed {
    logic                  valid;
    logic [CELL_BITS-1:0]  cluster;
    logic [CNT_BITS-1:0]   members;
    logic [SUM_BITS-1:0]   acc_z;
    logic [SUM_BITS-1:0]   acc_y;
    logic [SUM_BITS-1:0]   acc_x;
    logic [COORD_BITS-1:0] repr_z;
    logic [COORD_BITS-1:0] repr_y;
    logic [COORD_BITS-1:0] repr_x;
  } cell_t;

  typedef enum logic [1:0] {
    RD_CAND,
    RD_BEST,
    RD_ADDR
  } rd_sel_t;

  typedef struct packed {
    logic                 load_in;
    logic                 half_en;
    logic                 sq_en;
    logic [1:0]           axis;
    logic [2:0]           cand;
    logic                 rd_en;
    rd_sel_t              rd_sel;
    logic                 take_best;
    logic                 wr_clear;
    logic [CELL_BITS-1:0] clr_addr;
    logic                 wr_update;
    logic                 load_out_read;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic cand_ok;
    logic rd_valid;
    logic better;
    logic found;
  } sts_t;

  function automatic logic [RES_BITS-1:0] eff_res(input logic [RES_BITS-1:0] r);
    if (r == '0) begin
      return RES_BITS'(1);
    end else if (r > RES_BITS'(MAX_RES)) begin
      return RES_BITS'(MAX_RES);
    end
    return r;
  endfunction

  function automatic logic [CELL_BITS-1:0] cell_idx(input logic [CRD_BITS-1:0] x,
                                                    input logic [CRD_BITS-1:0] y,
                                                    input logic [CRD_BITS-1:0] z,
                                                    input logic [RES_BITS-1:0] rx,
                                                    input logic [RES_BITS-1:0] ry);
    logic [2*RES_BITS-1:0] rxy;
    logic [CELL_BITS+1:0]  s;
    rxy = {{RES_BITS{1'b0}}, rx} * {{RES_BITS{1'b0}}, ry};
    s = (CELL_BITS+2)'(x)
      + (CELL_BITS+2)'(y) * (CELL_BITS+2)'(rx)
      + (CELL_BITS+2)'(z) * (CELL_BITS+2)'(rxy);
    return s[CELL_BITS-1:0];
  endfunction

endpackage

// ===== rtl/gvca_ctrl.sv =====
// Sequencer for associate and read transactions, plus the post-reset clearing sweep.
module gvca_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  gvca_pkg::sts_t    sts,
  output gvca_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HALF, S_CAND, S_CWAIT, S_SQ, S_CMP,
    S_DEC, S_BWAIT, S_FIN, S_RRD, S_RWAIT, S_RFIN
  } state_t;

  state_t                         state;
  logic [1:0]                     axis;
  logic [2:0]                     cand;
  logic [gvca_pkg::CELL_BITS-1:0] clr_addr;
  logic                           out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd = '0;
    cmd.axis = axis;
    cmd.cand = cand;
    cmd.clr_addr = clr_addr;
    cmd.rd_sel = gvca_pkg::RD_CAND;
    case (state)
      S_CLEAR: cmd.wr_clear = 1'b1;
      S_IDLE:  cmd.load_in = in_valid;
      S_HALF:  cmd.half_en = 1'b1;
      S_CAND:  cmd.rd_en = sts.cand_ok;
      S_SQ:    cmd.sq_en = 1'b1;
      S_CMP:   cmd.take_best = sts.better;
      S_DEC: begin
        cmd.rd_en = sts.found;
        cmd.rd_sel = gvca_pkg::RD_BEST;
      end
      S_FIN:   cmd.wr_update = out_free;
      S_RRD: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = gvca_pkg::RD_ADDR;
      end
      S_RFIN:  cmd.load_out_read = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      axis <= '0;
      cand <= '0;
      clr_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          axis <= '0;
          cand <= '0;
          if (in_valid) begin
            state <= (sts.op == gvca_pkg::OP_READ) ? S_RRD : S_HALF;
          end
        end
        S_HALF: begin
          axis <= axis + 1'b1;
          if (axis == 2'd2) begin
            state <= S_CAND;
          end
        end
        S_CAND: begin
          if (sts.cand_ok) begin
            state <= S_CWAIT;
          end else if (&cand) begin
            state <= S_DEC;
          end else begin
            cand <= cand + 1'b1;
          end
        end
        S_CWAIT: begin
          axis <= '0;
          if (sts.rd_valid) begin
            state <= S_SQ;
          end else if (&cand) begin
            state <= S_DEC;
          end else begin
            cand <= cand + 1'b1;
            state <= S_CAND;
          end
        end
        S_SQ: begin
          axis <= axis + 1'b1;
          if (axis == 2'd2) begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (&cand) begin
            state <= S_DEC;
          end else begin
            cand <= cand + 1'b1;
            state <= S_CAND;
          end
        end
        S_DEC:   state <= sts.found ? S_BWAIT : S_FIN;
        S_BWAIT: state <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_RRD:   state <= S_RWAIT;
        S_RWAIT: state <= S_RFIN;
        S_RFIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/gvca_dp.sv =====
// Datapath: config registers, half-cell and distance arithmetic, cell store, result register.
module gvca_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [23:0]            cfg_data,
  input  gvca_pkg::in_t          in_item,
  output gvca_pkg::out_t         out_item,
  input  gvca_pkg::cmd_t         cmd,
  output gvca_pkg::sts_t         sts
);

  localparam int CB = gvca_pkg::CELL_BITS;
  localparam int WB = gvca_pkg::COORD_BITS;

  gvca_pkg::cell_t mem [gvca_pkg::MAX_CELLS];

  logic [gvca_pkg::RES_BITS-1:0]   res [3];
  logic [gvca_pkg::SCALE_BITS-1:0] scale [3];
  logic [gvca_pkg::RES_BITS-1:0]   reff [3];

  gvca_pkg::in_t                   inr;
  gvca_pkg::cell_t                 rdata;
  gvca_pkg::cell_t                 wdata;
  gvca_pkg::out_t                  outr;
  gvca_pkg::out_t                  rd_out;
  logic                            rvalid;
  logic [gvca_pkg::HALF_BITS-1:0]  hreg [3];
  logic [gvca_pkg::DIST_BITS-1:0]  dsum, bestd;
  logic [CB-1:0]                   best;
  logic                            found;
  logic [gvca_pkg::CTR_BITS-1:0]   ctr;

  logic [WB-1:0]                   pos [3];
  logic [WB-1:0]                   rep [3];
  logic [WB-1:0]                   ma, diff;
  logic [gvca_pkg::SCALE_BITS-1:0] mb;
  logic [gvca_pkg::PROD_BITS-1:0]  prod;
  logic [31:0]                     hraw;
  logic [gvca_pkg::HALF_BITS:0]    lim;
  logic [gvca_pkg::HALF_BITS-1:0]  hclamp;
  logic [gvca_pkg::CRD_BITS-1:0]   c [3];
  logic [gvca_pkg::CRD_BITS-1:0]   n [3];
  logic                            has [3];
  logic                            up [3];
  logic                            ok;
  logic [CB-1:0]                   centre, cand_addr, rd_addr, wr_addr;
  logic                            created;
  logic [gvca_pkg::CTR_BITS-1:0]   ctr_next;
  logic [gvca_pkg::SUM_BITS:0]     sx, sy, sz;
  logic [gvca_pkg::CNT_BITS-1:0]   mcnt;

  assign pos[0] = inr.pos_x;
  assign pos[1] = inr.pos_y;
  assign pos[2] = inr.pos_z;
  assign rep[0] = rdata.repr_x;
  assign rep[1] = rdata.repr_y;
  assign rep[2] = rdata.repr_z;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      reff[j] = gvca_pkg::eff_res(res[j]);
      c[j] = hreg[j][gvca_pkg::HALF_BITS-1:1];
      up[j] = hreg[j][0];
      has[j] = hreg[j][0] ? ({1'b0, hreg[j]} < {reff[j], 1'b0} - 1'b1) : (hreg[j] != '0);
    end
    ok = 1'b1;
    for (int j = 0; j < 3; j++) begin
      n[j] = c[j];
      if (cmd.cand[j]) begin
        if (!has[j]) begin
          ok = 1'b0;
        end else begin
          n[j] = up[j] ? c[j] + 1'b1 : c[j] - 1'b1;
        end
      end
    end
  end

  assign centre = gvca_pkg::cell_idx(c[0], c[1], c[2], reff[0], reff[1]);
  assign cand_addr = gvca_pkg::cell_idx(n[0], n[1], n[2], reff[0], reff[1]);

  assign diff = (pos[cmd.axis] > rep[cmd.axis]) ? pos[cmd.axis] - rep[cmd.axis]
                                                : rep[cmd.axis] - pos[cmd.axis];
  assign ma = cmd.half_en ? pos[cmd.axis] : diff;
  assign mb = cmd.half_en ? scale[cmd.axis] : diff;
  assign prod = gvca_pkg::PROD_BITS'(ma) * gvca_pkg::PROD_BITS'(mb);
  assign hraw = prod[47:16];
  assign lim = {reff[cmd.axis], 1'b0} - 1'b1;
  assign hclamp = (hraw > 32'(lim)) ? lim[gvca_pkg::HALF_BITS-1:0]
                                    : hraw[gvca_pkg::HALF_BITS-1:0];

  always_comb begin
    case (cmd.rd_sel)
      gvca_pkg::RD_CAND: rd_addr = cand_addr;
      gvca_pkg::RD_BEST: rd_addr = best;
      gvca_pkg::RD_ADDR: rd_addr = inr.cell_addr;
      default:           rd_addr = cand_addr;
    endcase
  end

  assign created = !found;
  assign ctr_next = (created && ctr < gvca_pkg::CTR_MAX) ? ctr + 1'b1 : ctr;
  assign sx = created ? (gvca_pkg::SUM_BITS+1)'(inr.pos_x)
                      : (gvca_pkg::SUM_BITS+1)'(rdata.acc_x) + (gvca_pkg::SUM_BITS+1)'(inr.pos_x);
  assign sy = created ? (gvca_pkg::SUM_BITS+1)'(inr.pos_y)
                      : (gvca_pkg::SUM_BITS+1)'(rdata.acc_y) + (gvca_pkg::SUM_BITS+1)'(inr.pos_y);
  assign sz = created ? (gvca_pkg::SUM_BITS+1)'(inr.pos_z)
                      : (gvca_pkg::SUM_BITS+1)'(rdata.acc_z) + (gvca_pkg::SUM_BITS+1)'(inr.pos_z);
  assign mcnt = created ? gvca_pkg::CNT_BITS'(1)
              : (rdata.members == gvca_pkg::CNT_MAX) ? rdata.members : rdata.members + 1'b1;

  always_comb begin
    wdata = '0;
    if (!cmd.wr_clear) begin
      wdata.valid = 1'b1;
      wdata.cluster = created ? ctr[CB-1:0] : rdata.cluster;
      wdata.members = mcnt;
      wdata.acc_x = sx[gvca_pkg::SUM_BITS] ? gvca_pkg::SUM_MAX : sx[gvca_pkg::SUM_BITS-1:0];
      wdata.acc_y = sy[gvca_pkg::SUM_BITS] ? gvca_pkg::SUM_MAX : sy[gvca_pkg::SUM_BITS-1:0];
      wdata.acc_z = sz[gvca_pkg::SUM_BITS] ? gvca_pkg::SUM_MAX : sz[gvca_pkg::SUM_BITS-1:0];
      wdata.repr_x = created ? inr.pos_x : rdata.repr_x;
      wdata.repr_y = created ? inr.pos_y : rdata.repr_y;
      wdata.repr_z = created ? inr.pos_z : rdata.repr_z;
    end
  end

  always_comb begin
    rd_out = '0;
    rd_out.vertex_out = inr.vertex_id;
    rd_out.cell_index = inr.cell_addr;
    rd_out.clusters_made = ctr;
    if (rdata.valid) begin
      rd_out.cluster_id = rdata.cluster;
      rd_out.cell_has_cluster = 1'b1;
      rd_out.sum_x = rdata.acc_x;
      rd_out.sum_y = rdata.acc_y;
      rd_out.sum_z = rdata.acc_z;
      rd_out.member_count = rdata.members;
    end
  end

  assign wr_addr = cmd.wr_clear ? cmd.clr_addr : (found ? best : centre);

  always_ff @(posedge clk) begin
    if (cmd.wr_clear || cmd.wr_update) begin
      mem[wr_addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res[0] <= 5'd1;
      res[1] <= 5'd1;
      res[2] <= 5'd1;
      scale[0] <= 24'd65536;
      scale[1] <= 24'd65536;
      scale[2] <= 24'd65536;
      ctr <= '0;
      found <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gvca_pkg::CFG_RES_X:   res[0] <= cfg_data[gvca_pkg::RES_BITS-1:0];
          gvca_pkg::CFG_RES_Y:   res[1] <= cfg_data[gvca_pkg::RES_BITS-1:0];
          gvca_pkg::CFG_RES_Z:   res[2] <= cfg_data[gvca_pkg::RES_BITS-1:0];
          gvca_pkg::CFG_SCALE_X: scale[0] <= cfg_data;
          gvca_pkg::CFG_SCALE_Y: scale[1] <= cfg_data;
          gvca_pkg::CFG_SCALE_Z: scale[2] <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load_in) begin
        found <= 1'b0;
      end else if (cmd.take_best) begin
        found <= 1'b1;
      end
      if (cmd.wr_update) begin
        ctr <= ctr_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      inr <= in_item;
    end
    if (cmd.rd_en) begin
      rvalid <= 1'b1;
    end
    if (cmd.half_en) begin
      hreg[cmd.axis] <= hclamp;
    end
    if (cmd.sq_en) begin
      dsum <= (cmd.axis == 2'd0) ? gvca_pkg::DIST_BITS'(prod)
                                 : dsum + gvca_pkg::DIST_BITS'(prod);
    end
    if (cmd.take_best) begin
      bestd <= dsum;
      best <= cand_addr;
    end
    if (cmd.wr_update) begin
      outr.vertex_out <= inr.vertex_id;
      outr.cell_index <= wr_addr;
      outr.cluster_id <= wdata.cluster;
      outr.created <= created;
      outr.cell_has_cluster <= 1'b1;
      outr.sum_x <= wdata.acc_x;
      outr.sum_y <= wdata.acc_y;
      outr.sum_z <= wdata.acc_z;
      outr.member_count <= wdata.members;
      outr.clusters_made <= ctr_next;
    end else if (cmd.load_out_read) begin
      outr <= rd_out;
    end
  end

  assign out_item = outr;
  assign sts.op = in_item.op;
  assign sts.cand_ok = ok;
  assign sts.rd_valid = rdata.valid && rvalid;
  assign sts.better = !found || (dsum < bestd);
  assign sts.found = found;

endmodule

// ===== rtl/grid_vertex_cluster_assign_top.sv =====
// Top level of the grid vertex cluster assign block.
//   channel  dir  handshake            payload
//   in       in   in_valid/in_ready    gvca_pkg::in_t
//   out      out  out_valid/out_ready  gvca_pkg::out_t
//   cfg      in   cfg_we               cfg_index, cfg_data
// Associate: a half-cell step per axis, then per candidate (centre plus seven neighbors)
//   a skip, a store read, or a read and distance test; a joined cluster rereads its best
//   cell; bounded by the single store port and multiplier. One transaction in flight; the next
//   is taken while a result waits. After reset a sweep clears all 4096 cells; in_ready stays low.
// A stalled result holds the store write and result load until out_ready.
module grid_vertex_cluster_assign_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  gvca_pkg::in_t  in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output gvca_pkg::out_t out_item,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [23:0]    cfg_data
);

  gvca_pkg::cmd_t cmd;
  gvca_pkg::sts_t sts;

  gvca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gvca_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .out_item  (out_item),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== rtl/gvca_checker.sv =====
// Port-level checks for the grid vertex cluster assign block, bound to the top level.
module gvca_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input gvca_pkg::out_t out_item
);

  a_clear_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input taken during clearing sweep");

  a_created_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.created |-> out_item.cell_has_cluster && out_item.member_count == 21'd1)
    else $error("new cluster without single member");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.cell_has_cluster |->
      out_item.member_count == '0 && out_item.sum_x == '0 && !out_item.created)
    else $error("empty cell reports contents");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled transaction changed");

endmodule

bind grid_vertex_cluster_assign_top gvca_checker u_gvca_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
